/* src/mbh_pkg.sv */
// Shared constants and types for the bucket hash block.
package mbh_pkg;

    localparam int KEY_W = 32;
    localparam int BV_W  = 3;
    localparam int IDX_W = 24;
    localparam int BB_W  = 5;
    localparam int LEN_W = 32;

    localparam logic [KEY_W-1:0] SEED_INIT = 32'h9747b28c;
    localparam logic [KEY_W-1:0] MIX_C1    = 32'hcc9e2d51;
    localparam logic [KEY_W-1:0] MIX_C2    = 32'h1b873593;
    localparam logic [KEY_W-1:0] MIX_ADD   = 32'he6546b64;
    localparam logic [KEY_W-1:0] FIN_M1    = 32'h85ebca6b;
    localparam logic [KEY_W-1:0] FIN_M2    = 32'hc2b2ae35;
    localparam logic [KEY_W-1:0] MUL_FIVE  = 32'd5;

    localparam logic [BB_W-1:0] BB_RESET = 5'd16;
    localparam logic [BV_W-1:0] BV_FULL  = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL2,
        S_MIX,
        S_ADD,
        S_FIN0,
        S_FIN1,
        S_FIN2
    } mbh_state_t;

endpackage

/* src/mbh_key_if.sv */
// Key chunk channel: valid/ready plus one chunk of key bytes.
interface mbh_key_if
    import mbh_pkg::*;
    ;
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] key_word;
    logic [BV_W-1:0]  byte_valid;
    logic             last_chunk;

    modport source (output valid, output key_word, output byte_valid, output last_chunk,
                    input ready);
    modport sink   (input valid, input key_word, input byte_valid, input last_chunk,
                    output ready);
endinterface

/* src/mbh_idx_if.sv */
// Bucket index channel: valid/ready plus the masked hash.
interface mbh_idx_if
    import mbh_pkg::*;
    ;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] bucket_idx;

    modport source (output valid, output bucket_idx, input ready);
    modport sink   (input valid, input bucket_idx, output ready);
endinterface

/* src/mbh_mul.sv */
// Shared 32x32 multiplier, low half of the product, registered.
module mbh_mul
    import mbh_pkg::*;
(
    input  logic             clk,
    input  logic [KEY_W-1:0] a,
    input  logic [KEY_W-1:0] b,
    output logic [KEY_W-1:0] p
);

    logic [KEY_W-1:0] prod_lo;
    logic [KEY_W-1:0] p_reg;

    assign prod_lo = a * b;

    always_ff @(posedge clk)
    begin
        p_reg <= prod_lo;
    end

    assign p = p_reg;

endmodule

/* src/mbh_seq.sv */
// Sequencer and hash state: drives the shared multiplier step by step.
module mbh_seq
    import mbh_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    mbh_key_if.sink          key_in,
    mbh_idx_if.source        idx_out,
    input  logic [IDX_W-1:0] idx_mask,
    output logic [KEY_W-1:0] mul_a,
    output logic [KEY_W-1:0] mul_b,
    input  logic [KEY_W-1:0] mul_p
);

    mbh_state_t       state_reg, state_next;
    logic [KEY_W-1:0] h_reg, h_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [BV_W-1:0]  n_reg, n_next;
    logic             last_reg, last_next;
    logic             out_valid_reg, out_valid_next;
    logic [IDX_W-1:0] out_data_reg, out_data_next;

    logic             accept;
    logic [BV_W-1:0]  n_in;
    logic [KEY_W-1:0] k_in;
    logic [KEY_W-1:0] mix_t;
    logic [KEY_W-1:0] fin_t;
    logic [KEY_W-1:0] fin_x;
    logic             out_free;

    function automatic logic [KEY_W-1:0] rotl15(input logic [KEY_W-1:0] v);
        rotl15 = {v[KEY_W-16:0], v[KEY_W-1:KEY_W-15]};
    endfunction

    function automatic logic [KEY_W-1:0] rotl13(input logic [KEY_W-1:0] v);
        rotl13 = {v[KEY_W-14:0], v[KEY_W-1:KEY_W-13]};
    endfunction

    assign key_in.ready = (state_reg == S_IDLE);
    assign accept       = key_in.valid && key_in.ready;
    assign out_free     = !out_valid_reg || idx_out.ready;

    // byte count: non-final chunks always count as a full block
    always_comb
    begin
        if (!key_in.last_chunk || key_in.byte_valid > BV_FULL)
            n_in = BV_FULL;
        else
            n_in = key_in.byte_valid;
    end

    // drop bytes beyond the count in a tail
    always_comb
    begin
        case (n_in)
            3'd1:    k_in = {24'd0, key_in.key_word[7:0]};
            3'd2:    k_in = {16'd0, key_in.key_word[15:0]};
            3'd3:    k_in = {8'd0, key_in.key_word[23:0]};
            default: k_in = key_in.key_word;
        endcase
    end

    assign mix_t = h_reg ^ mul_p;
    assign fin_t = h_reg ^ len_reg;
    assign fin_x = mul_p ^ (mul_p >> 16);

    always_comb
    begin
        state_next     = state_reg;
        h_next         = h_reg;
        len_next       = len_reg;
        n_next         = n_reg;
        last_next      = last_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !idx_out.ready;
        mul_a          = k_in;
        mul_b          = MIX_C1;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    n_next    = n_in;
                    last_next = key_in.last_chunk;
                    len_next  = len_reg + LEN_W'(n_in);
                    state_next = (n_in == 3'd0) ? S_FIN0 : S_MUL2;
                end
            end
            S_MUL2:
            begin
                mul_a      = rotl15(mul_p);
                mul_b      = MIX_C2;
                state_next = S_MIX;
            end
            S_MIX:
            begin
                mul_a = rotl13(mix_t);
                mul_b = MUL_FIVE;
                if (n_reg == BV_FULL)
                    state_next = S_ADD;
                else
                begin
                    // tail mix: no rotate or seed update
                    h_next     = mix_t;
                    state_next = S_FIN0;
                end
            end
            S_ADD:
            begin
                h_next     = mul_p + MIX_ADD;
                state_next = last_reg ? S_FIN0 : S_IDLE;
            end
            S_FIN0:
            begin
                mul_a      = fin_t ^ (fin_t >> 16);
                mul_b      = FIN_M1;
                state_next = S_FIN1;
            end
            S_FIN1:
            begin
                mul_a      = mul_p ^ (mul_p >> 13);
                mul_b      = FIN_M2;
                state_next = S_FIN2;
            end
            S_FIN2:
            begin
                // hold the product until the output register frees up
                mul_a = mul_p;
                mul_b = 32'd1;
                if (out_free)
                begin
                    out_data_next  = fin_x[IDX_W-1:0] & idx_mask;
                    out_valid_next = 1'b1;
                    h_next         = SEED_INIT;
                    len_next       = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            h_reg         <= SEED_INIT;
            len_reg       <= '0;
            n_reg         <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            h_reg         <= h_next;
            len_reg       <= len_next;
            n_reg         <= n_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign idx_out.valid      = out_valid_reg;
    assign idx_out.bucket_idx = out_data_reg;

endmodule

/* src/murmur3_bucket_hash_top.sv */
// Top level of the MurmurHash3 x86_32 bucket index block.
//
// Hashes a key that arrives as little-endian 32-bit chunks (first byte in
// bits 7:0) with MurmurHash3 x86_32, seed 0x9747b28c, and returns the hash
// masked to bucket_bits low bits as one index item per key. All chunks
// before the last are mixed as full 4-byte blocks; the last chunk carries
// 0..4 bytes (values above 4 count as 4). All multiplies go through one
// registered 32x32 multiplier, so the block takes one chunk at a time:
// a chunk is accepted and multiplied by c1, then by c2, then mixed
// into the hash (a full block also via the times-5 multiply and the add;
// an empty final chunk skips all this); after the last chunk come the two
// finalizer multiplies and the output step. The index item appears in the
// output register the cycle after the last step and can wait there while
// the next key streams in; the block stalls at the output step only if an
// earlier index is still untaken. bucket_bits resets to 16; odd values or
// values outside 10..24 act as 16. Write it only while the block is idle.
module murmur3_bucket_hash_top
    import mbh_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  logic [BB_W-1:0] cfg_wr_data,
    mbh_key_if.sink         key_in,
    mbh_idx_if.source       idx_out
);

    logic [BB_W-1:0]  bucket_bits_reg;
    logic [BB_W-1:0]  eff_bits;
    logic [IDX_W-1:0] idx_mask;

    logic [KEY_W-1:0] mul_a;
    logic [KEY_W-1:0] mul_b;
    logic [KEY_W-1:0] mul_p;

    // bucket width register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bucket_bits_reg <= BB_RESET;
        else if (cfg_wr_en)
            bucket_bits_reg <= cfg_wr_data;
    end

    // only even widths 10..24 are honored
    always_comb
    begin
        if (bucket_bits_reg inside {[5'd10:5'd24]} && !bucket_bits_reg[0])
            eff_bits = bucket_bits_reg;
        else
            eff_bits = BB_RESET;
    end

    // a shift by the full width leaves all ones
    assign idx_mask = ~({IDX_W{1'b1}} << eff_bits);

    mbh_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .key_in   (key_in),
        .idx_out  (idx_out),
        .idx_mask (idx_mask),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .mul_p    (mul_p)
    );

    mbh_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

endmodule
